// ===== rtl/lbo_pkg.sv =====
// Package: shared types and constants for the lat/lon box overlap ratio unit.
`timescale 1ns / 1ps

package lbo_pkg;

  localparam int RATIO_BITS_DEF = 16;
  localparam int THR_W          = 17;
  localparam logic [THR_W-1:0] THR_RESET = 17'd45875;

  // edge widths
  localparam int LAT_W = 18;   // north/south input width
  localparam int LON_W = 21;   // west/east input width
  localparam int NW    = 24;   // working longitude width
  localparam int HU_W  = 18;   // height magnitude width
  localparam int WU_W  = 24;   // width magnitude width
  localparam int PW    = HU_W + WU_W;

  localparam logic signed [NW-1:0]    TURN        = 24'sd360000;
  localparam logic signed [LAT_W-1:0] SOUTH_LIMIT = -18'sd78000;
  localparam logic signed [LAT_W-1:0] SOUTH_POLE  = -18'sd90000;

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_MISSING     = 2'd1,
    ST_EMPTY_UNION = 2'd2,
    ST_DEGENERATE  = 2'd3
  } status_t;

  // how the ratio is formed
  typedef enum logic [1:0] {
    MODE_AREA,
    MODE_LEN_W,
    MODE_LEN_H
  } mode_t;

  typedef enum logic {
    F_IDLE,
    F_NORM
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_CHK,
    B_DIV
  } back_state_t;

  typedef struct packed {
    logic            skip;        // result is fixed, no division
    logic            skip_match;
    status_t         status;
    mode_t           mode;
    logic            ineg;        // intersection has negative extent
    logic [HU_W-1:0] hu;
    logic [WU_W-1:0] wu;
    logic [HU_W-1:0] hi;
    logic [WU_W-1:0] wi;
  } q_item_t;

endpackage

// ===== rtl/lbo_front.sv =====
// Front end: accepts a box pair, normalizes longitudes and classifies the union.
`timescale 1ns / 1ps

module lbo_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        a_has_area,
  input  logic signed [17:0]          a_north,
  input  logic signed [17:0]          a_south,
  input  logic signed [20:0]          a_west,
  input  logic signed [20:0]          a_east,
  input  logic                        a_param_is_140,
  input  logic                        b_has_area,
  input  logic signed [17:0]          b_north,
  input  logic signed [17:0]          b_south,
  input  logic signed [20:0]          b_west,
  input  logic signed [20:0]          b_east,
  input  logic                        b_param_is_140,
  output logic                        q_push,
  input  logic                        q_full,
  output lbo_pkg::q_item_t            q_data
);

  localparam int NW = lbo_pkg::NW;
  localparam int LW = lbo_pkg::LAT_W;

  lbo_pkg::front_state_t state, state_next;

  logic ha, hb;
  logic signed [LW-1:0] n1, s1, n2, s2;
  logic signed [NW-1:0] w1, e1, w2, e2;

  logic done1, done2, done;
  assign done1 = (w1 < e1) && (w1 >= 0);
  assign done2 = (w2 < e2) && (w2 >= 0);
  assign done  = done1 && done2;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lbo_pkg::F_IDLE: if (push) state_next = lbo_pkg::F_NORM;
      lbo_pkg::F_NORM: if (done && !q_full) state_next = lbo_pkg::F_IDLE;
      default:         state_next = lbo_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full   = 1'b1;
    q_push = 1'b0;
    case (state)
      lbo_pkg::F_IDLE: full = 1'b0;
      lbo_pkg::F_NORM: q_push = done && !q_full;
      default:         full = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lbo_pkg::F_IDLE;
    else     state <= state_next;
  end

  // box registers: load with pole clamp, then one turn per cycle
  always_ff @(posedge clk) begin
    if (state == lbo_pkg::F_IDLE && push) begin
      ha <= a_has_area;
      hb <= b_has_area;
      n1 <= a_north;
      n2 <= b_north;
      s1 <= (a_param_is_140 && a_south <= lbo_pkg::SOUTH_LIMIT) ? lbo_pkg::SOUTH_POLE : a_south;
      s2 <= (b_param_is_140 && b_south <= lbo_pkg::SOUTH_LIMIT) ? lbo_pkg::SOUTH_POLE : b_south;
      w1 <= NW'(a_west);
      e1 <= NW'(a_east);
      w2 <= NW'(b_west);
      e2 <= NW'(b_east);
    end else if (state == lbo_pkg::F_NORM) begin
      if (w1 >= e1) begin
        w1 <= w1 - lbo_pkg::TURN;
      end else if (w1 < 0) begin
        w1 <= w1 + lbo_pkg::TURN;
        e1 <= e1 + lbo_pkg::TURN;
      end
      if (w2 >= e2) begin
        w2 <= w2 - lbo_pkg::TURN;
      end else if (w2 < 0) begin
        w2 <= w2 + lbo_pkg::TURN;
        e2 <= e2 + lbo_pkg::TURN;
      end
    end
  end

  // union and intersection extents
  logic signed [LW-1:0] un, us, in_n, is_s;
  logic signed [NW-1:0] ue, uw, ie, iw;
  logic signed [LW:0]   hn, ih;
  logic signed [NW:0]   wd, iwd;

  always_comb begin
    un   = (n1 > n2) ? n1 : n2;
    us   = (s1 < s2) ? s1 : s2;
    in_n = (n1 < n2) ? n1 : n2;
    is_s = (s1 > s2) ? s1 : s2;
    ue   = (e1 > e2) ? e1 : e2;
    uw   = (w1 < w2) ? w1 : w2;
    ie   = (e1 < e2) ? e1 : e2;
    iw   = (w1 > w2) ? w1 : w2;
    hn   = {un[LW-1], un} - {us[LW-1], us};
    ih   = {in_n[LW-1], in_n} - {is_s[LW-1], is_s};
    wd   = {ue[NW-1], ue} - {uw[NW-1], uw};
    iwd  = {ie[NW-1], ie} - {iw[NW-1], iw};
  end

  // classification
  always_comb begin
    q_data            = '0;
    q_data.status     = lbo_pkg::ST_OK;
    q_data.mode       = lbo_pkg::MODE_AREA;
    q_data.hu         = hn[lbo_pkg::HU_W-1:0];
    q_data.hi         = ih[lbo_pkg::HU_W-1:0];
    q_data.wu         = wd[lbo_pkg::WU_W-1:0];
    q_data.wi         = iwd[lbo_pkg::WU_W-1:0];
    q_data.ineg       = ih[LW] || iwd[NW];
    if (!ha || !hb) begin
      q_data.skip       = 1'b1;
      q_data.skip_match = !ha && !hb;
      q_data.status     = lbo_pkg::ST_MISSING;
    end else if (hn[LW] || wd[NW]) begin
      q_data.skip   = 1'b1;
      q_data.status = lbo_pkg::ST_EMPTY_UNION;
    end else if (hn == 0) begin
      if (wd == 0) begin
        q_data.skip   = 1'b1;
        q_data.status = lbo_pkg::ST_DEGENERATE;
      end else if (ih != 0) begin
        q_data.skip = 1'b1;
      end else begin
        q_data.mode = lbo_pkg::MODE_LEN_W;
      end
    end else if (wd == 0) begin
      if (iwd != 0) q_data.skip = 1'b1;
      else          q_data.mode = lbo_pkg::MODE_LEN_H;
    end
  end

endmodule

// ===== rtl/lbo_queue.sv =====
// Short register queue between the front and back ends.
`timescale 1ns / 1ps

module lbo_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  lbo_pkg::q_item_t  wr_data,
  output logic              q_full,
  input  logic              rd_en,
  output lbo_pkg::q_item_t  rd_data,
  output logic              q_empty
);

  localparam int D  = lbo_pkg::QDEPTH;
  localparam int AW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  lbo_pkg::q_item_t mem [D];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] count;

  assign q_full  = (count == CW'(D));
  assign q_empty = (count == '0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

  // pointers wrap at depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr_en) wp <= (wp == AW'(D - 1)) ? '0 : wp + 1'b1;
      if (rd_en) rp <= (rp == AW'(D - 1)) ? '0 : rp + 1'b1;
      if (wr_en && !rd_en)      count <= count + 1'b1;
      else if (!wr_en && rd_en) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/lbo_back.sv =====
// Back end: area products, restoring divider and result register.
`timescale 1ns / 1ps

module lbo_back #(
  parameter int RATIO_BITS = lbo_pkg::RATIO_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lbo_pkg::q_item_t              q_data,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [lbo_pkg::THR_W-1:0]     threshold,
  output logic                          res_valid,
  input  logic                          res_pop,
  output logic [RATIO_BITS:0]           res_ratio,
  output logic                          res_match,
  output lbo_pkg::status_t              res_status
);

  localparam int PW    = lbo_pkg::PW;
  localparam int RB    = RATIO_BITS;
  localparam int CNT_W = $clog2(RB + 1);
  localparam int CMP_W = (RB + 1 > lbo_pkg::THR_W) ? RB + 1 : lbo_pkg::THR_W;

  lbo_pkg::back_state_t state, state_next;
  lbo_pkg::q_item_t     item;

  logic [PW-1:0]    num, den, rem;
  logic [RB-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic [PW:0]      rem2;
  logic             fit;
  logic             last;

  assign rem2 = {rem, 1'b0};
  assign fit  = rem2 >= {1'b0, den};
  assign last = (cnt == CNT_W'(RB - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lbo_pkg::B_IDLE: if (q_pop && !q_data.skip) state_next = lbo_pkg::B_MUL;
      lbo_pkg::B_MUL:  state_next = lbo_pkg::B_CHK;
      lbo_pkg::B_CHK:  if (num >= den) state_next = lbo_pkg::B_IDLE;
                       else            state_next = lbo_pkg::B_DIV;
      lbo_pkg::B_DIV:  if (last) state_next = lbo_pkg::B_IDLE;
      default:         state_next = lbo_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop = 1'b0;
    case (state)
      lbo_pkg::B_IDLE: q_pop = !q_empty && !res_valid;
      default:         q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lbo_pkg::B_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      lbo_pkg::B_IDLE: if (q_pop) item <= q_data;
      lbo_pkg::B_MUL: begin
        case (item.mode)
          lbo_pkg::MODE_LEN_W: begin
            den <= PW'(item.wu);
            num <= item.ineg ? '0 : PW'(item.wi);
          end
          lbo_pkg::MODE_LEN_H: begin
            den <= PW'(item.hu);
            num <= item.ineg ? '0 : PW'(item.hi);
          end
          default: begin
            den <= item.hu * item.wu;
            num <= item.ineg ? '0 : item.hi * item.wi;
          end
        endcase
      end
      lbo_pkg::B_CHK: begin
        rem <= num;
        quo <= '0;
        cnt <= '0;
      end
      lbo_pkg::B_DIV: begin
        rem <= fit ? PW'(rem2 - {1'b0, den}) : rem2[PW-1:0];
        quo <= {quo[RB-2:0], fit};
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  logic [RB:0] final_ratio;
  always_comb begin
    if (state == lbo_pkg::B_CHK) final_ratio = {1'b1, {RB{1'b0}}};
    else                         final_ratio = {1'b0, quo[RB-2:0], fit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == lbo_pkg::B_IDLE) && q_pop && q_data.skip) begin
      res_valid <= 1'b1;
    end else if (((state == lbo_pkg::B_CHK) && (num >= den)) ||
                 ((state == lbo_pkg::B_DIV) && last)) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == lbo_pkg::B_IDLE) && q_pop && q_data.skip) begin
      res_ratio  <= '0;
      res_match  <= q_data.skip_match;
      res_status <= q_data.status;
    end else if (((state == lbo_pkg::B_CHK) && (num >= den)) ||
                 ((state == lbo_pkg::B_DIV) && last)) begin
      res_ratio  <= final_ratio;
      res_match  <= CMP_W'(final_ratio) > CMP_W'(threshold);
      res_status <= lbo_pkg::ST_OK;
    end
  end

endmodule

// ===== rtl/latlon_box_overlap_ratio_unit.sv =====
// Top level of the lat/lon box overlap ratio unit.
// Longitude normalization in the front end moves each box by one turn per
// cycle; the back end then forms the products, checks the range and runs the
// restoring divider, one quotient bit per cycle.
// The back end takes a new pair from the queue only once idle and its last result is popped.
// Reset: synchronous, clears both ends and the queue; threshold returns to 0.7.
`timescale 1ns / 1ps

module latlon_box_overlap_ratio_unit #(
  parameter int RATIO_BITS = lbo_pkg::RATIO_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [16:0]               cfg_wdata,
  input  logic                      push,
  output logic                      full,
  input  logic                      a_has_area,
  input  logic signed [17:0]        a_north,
  input  logic signed [17:0]        a_south,
  input  logic signed [20:0]        a_west,
  input  logic signed [20:0]        a_east,
  input  logic                      a_param_is_140,
  input  logic                      b_has_area,
  input  logic signed [17:0]        b_north,
  input  logic signed [17:0]        b_south,
  input  logic signed [20:0]        b_west,
  input  logic signed [20:0]        b_east,
  input  logic                      b_param_is_140,
  output logic                      empty,
  input  logic                      pop,
  output logic [RATIO_BITS:0]       overlap_ratio,
  output logic                      areas_match,
  output logic [1:0]                status
);

  logic [lbo_pkg::THR_W-1:0] match_threshold;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst)         match_threshold <= lbo_pkg::THR_RESET;
    else if (cfg_we) match_threshold <= cfg_wdata;
  end

  lbo_pkg::q_item_t fq_data, bq_data;
  logic             fq_push, fq_full, bq_pop, bq_empty;
  logic             res_valid;
  lbo_pkg::status_t res_status;

  lbo_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .a_has_area     (a_has_area),
    .a_north        (a_north),
    .a_south        (a_south),
    .a_west         (a_west),
    .a_east         (a_east),
    .a_param_is_140 (a_param_is_140),
    .b_has_area     (b_has_area),
    .b_north        (b_north),
    .b_south        (b_south),
    .b_west         (b_west),
    .b_east         (b_east),
    .b_param_is_140 (b_param_is_140),
    .q_push         (fq_push),
    .q_full         (fq_full),
    .q_data         (fq_data)
  );

  lbo_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_push),
    .wr_data (fq_data),
    .q_full  (fq_full),
    .rd_en   (bq_pop),
    .rd_data (bq_data),
    .q_empty (bq_empty)
  );

  lbo_back #(
    .RATIO_BITS (RATIO_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (bq_data),
    .q_empty    (bq_empty),
    .q_pop      (bq_pop),
    .threshold  (match_threshold),
    .res_valid  (res_valid),
    .res_pop    (pop),
    .res_ratio  (overlap_ratio),
    .res_match  (areas_match),
    .res_status (res_status)
  );

  assign empty  = !res_valid;
  assign status = res_status;

endmodule

// ===== dv/latlon_box_overlap_ratio_unit_test.sv =====
// Testbench for the lat/lon box overlap ratio unit: directed table plus random boxes.
`timescale 1ns / 1ps

module latlon_box_overlap_ratio_unit_test;

  localparam int RB = lbo_pkg::RATIO_BITS_DEF;
  localparam longint LTURN = 360000;

  typedef struct {
    logic ha;
    logic signed [17:0] an, as_;
    logic signed [20:0] aw, ae;
    logic ap;
    logic hb;
    logic signed [17:0] bn, bs;
    logic signed [20:0] bw, be;
    logic bp;
  } box_pair_t;

  typedef struct {
    logic [RB:0] ratio;
    logic match;
    lbo_pkg::status_t st;
  } overlap_t;

  // directed row: expected result only typed in where obvious
  typedef struct {
    box_pair_t bx;
    logic known;
    overlap_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic push = 1'b0;
  logic full;
  logic a_has_area = 0, a_param_is_140 = 0, b_has_area = 0, b_param_is_140 = 0;
  logic signed [17:0] a_north = 0, a_south = 0, b_north = 0, b_south = 0;
  logic signed [20:0] a_west = 0, a_east = 0, b_west = 0, b_east = 0;
  logic empty;
  logic pop = 1'b0;
  logic [RB:0] overlap_ratio;
  logic areas_match;
  logic [1:0] status;

  logic [16:0] thresh;
  overlap_t expected_q[$];
  int errors = 0;
  bit hold_rx = 0;
  bit fill_test = 0;

  always #5 clk = ~clk;

  latlon_box_overlap_ratio_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full),
    .a_has_area(a_has_area), .a_north(a_north), .a_south(a_south),
    .a_west(a_west), .a_east(a_east), .a_param_is_140(a_param_is_140),
    .b_has_area(b_has_area), .b_north(b_north), .b_south(b_south),
    .b_west(b_west), .b_east(b_east), .b_param_is_140(b_param_is_140),
    .empty(empty), .pop(pop), .overlap_ratio(overlap_ratio),
    .areas_match(areas_match), .status(status)
  );

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // bring west below east, then shift both up by whole turns until west is not negative
  function automatic void wrap_lon(ref longint w, ref longint e);
    longint k;
    if (w >= e) begin
      k = (w - e) / LTURN + 1;
      w -= k * LTURN;
    end
    if (w < 0) begin
      k = (-w + LTURN - 1) / LTURN;
      w += k * LTURN;
      e += k * LTURN;
    end
  endfunction

  function automatic longint lmin(longint x, longint y);
    return x < y ? x : y;
  endfunction

  function automatic longint lmax(longint x, longint y);
    return x > y ? x : y;
  endfunction

  // Q1.RB quotient, truncated, saturated at one
  function automatic logic [RB:0] q_ratio(longint num, longint den);
    longint q, r;
    q = 0;
    r = num;
    if (num >= den) return (RB+1)'(1) << RB;
    for (int i = 0; i < RB; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return q[RB:0];
  endfunction

  function automatic overlap_t predict_overlap(box_pair_t b);
    overlap_t o;
    longint n1, s1, w1, e1, n2, s2, w2, e2;
    longint un, us, ue, uw, inn, is, ie, iw, ua, ia;
    bit zero;
    o.ratio = '0;
    o.match = 1'b0;
    o.st = lbo_pkg::ST_OK;
    if (!b.ha || !b.hb) begin
      o.match = !b.ha && !b.hb;
      o.st = lbo_pkg::ST_MISSING;
      return o;
    end
    n1 = b.an; s1 = b.as_; w1 = b.aw; e1 = b.ae;
    n2 = b.bn; s2 = b.bs; w2 = b.bw; e2 = b.be;
    if (b.ap && s1 <= -78000) s1 = -90000;
    if (b.bp && s2 <= -78000) s2 = -90000;
    wrap_lon(w1, e1);
    wrap_lon(w2, e2);
    un = lmax(n1, n2); us = lmin(s1, s2);
    ue = lmax(e1, e2); uw = lmin(w1, w2);
    inn = lmin(n1, n2); is = lmax(s1, s2);
    ie = lmin(e1, e2); iw = lmax(w1, w2);
    if (un - us < 0 || ue - uw < 0) begin
      o.st = lbo_pkg::ST_EMPTY_UNION;
      return o;
    end
    zero = 0;
    ua = (un - us) * (ue - uw);
    ia = (inn - is) * (ie - iw);
    if (ua == 0) begin
      if (un == us) begin
        if (!(ue > uw)) o.st = lbo_pkg::ST_DEGENERATE;
        else if (inn != is) zero = 1;
        else begin
          ua = ue - uw;
          ia = ie - iw;
        end
      end
      if (o.st == lbo_pkg::ST_OK && !zero && ue == uw) begin
        if (un == us) o.st = lbo_pkg::ST_DEGENERATE;
        else if (ie != iw) zero = 1;
        else begin
          ua = un - us;
          ia = inn - is;
        end
      end
      if (o.st == lbo_pkg::ST_OK && !zero && !(ua > 0)) o.st = lbo_pkg::ST_DEGENERATE;
    end
    if (o.st == lbo_pkg::ST_OK && !zero) begin
      if (inn - is < 0 || ie - iw < 0 || ia < 0) ia = 0;
      o.ratio = q_ratio(ia, ua);
    end
    if (o.st == lbo_pkg::ST_OK) o.match = o.ratio > thresh;
    return o;
  endfunction

  function automatic box_pair_t mk(logic ha, int an, int as_, int aw, int ae, logic ap,
                                   logic hb, int bn, int bs, int bw, int be, logic bp);
    box_pair_t b;
    b.ha = ha; b.an = 18'(an); b.as_ = 18'(as_); b.aw = 21'(aw); b.ae = 21'(ae); b.ap = ap;
    b.hb = hb; b.bn = 18'(bn); b.bs = 18'(bs); b.bw = 21'(bw); b.be = 21'(be); b.bp = bp;
    return b;
  endfunction

  function automatic int rnd_range(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // mostly in-range boxes, sometimes raw bit patterns
  function automatic box_pair_t rand_pair();
    box_pair_t b;
    int c, h, wd;
    c = $urandom_range(15);
    b.ha = ($urandom_range(15) != 0);
    b.hb = ($urandom_range(15) != 0);
    b.ap = 1'($urandom_range(1));
    b.bp = 1'($urandom_range(1));
    if (c == 0) begin
      {b.an, b.as_, b.aw, b.ae} = 78'({$urandom, $urandom, $urandom});
      {b.bn, b.bs, b.bw, b.be} = 78'({$urandom, $urandom, $urandom});
    end else begin
      b.an = 18'(rnd_range(-90000, 90000));
      b.as_ = 18'((c < 12) ? rnd_range(-90000, int'(b.an)) : rnd_range(-90000, 90000));
      b.aw = 21'(rnd_range(-720000, 720000));
      b.ae = 21'((c < 12) ? b.aw + rnd_range(0, 120000) : rnd_range(-720000, 720000));
      if (c < 10) begin
        // second box near the first for real overlap
        h = rnd_range(-20000, 20000);
        wd = rnd_range(-20000, 20000);
        b.bn = 18'(lmin(90000, lmax(-90000, b.an + h)));
        b.bs = 18'(lmin(90000, lmax(-90000, b.as_ + rnd_range(-20000, 20000))));
        b.bw = 21'(b.aw + wd + LTURN * rnd_range(-1, 1));
        b.be = 21'(b.ae + rnd_range(-20000, 20000) + LTURN * rnd_range(-1, 1));
        if ($urandom_range(7) == 0) begin
          b.bn = b.an; b.bs = b.as_; b.bw = b.aw; b.be = b.ae;
        end
      end else begin
        b.bn = 18'(rnd_range(-90000, 90000));
        b.bs = 18'(rnd_range(-90000, 90000));
        b.bw = 21'(rnd_range(-720000, 720000));
        b.be = 21'(rnd_range(-720000, 720000));
      end
    end
    return b;
  endfunction

  task automatic send_pair(box_pair_t b);
    if ($urandom_range(3) == 0 && !fill_test) begin
      push <= 1'b0;
      repeat ($urandom_range(9) == 0 ? $urandom_range(40) : $urandom_range(3))
        @(posedge clk);
    end
    push <= 1'b1;
    a_has_area <= b.ha; a_north <= b.an; a_south <= b.as_;
    a_west <= b.aw; a_east <= b.ae; a_param_is_140 <= b.ap;
    b_has_area <= b.hb; b_north <= b.bn; b_south <= b.bs;
    b_west <= b.bw; b_east <= b.be; b_param_is_140 <= b.bp;
    do @(posedge clk); while (full);
    expected_q.push_back(predict_overlap(b));
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_thresh(logic [16:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    thresh = v;
  endtask

  // result side: random stalls, check each beat
  initial begin
    overlap_t w;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat", overlap_ratio, 0);
        end else begin
          w = expected_q.pop_front();
          if (overlap_ratio !== w.ratio) report("overlap_ratio", overlap_ratio, w.ratio);
          if (areas_match !== w.match) report("areas_match", areas_match, w.match);
          if (status !== w.st) report("status", status, w.st);
        end
      end
      if (hold_rx) pop <= 1'b0;
      else if ($urandom_range(15) == 0) pop <= 1'b0;
      else pop <= ($urandom_range(3) != 0) || ($urandom_range(1) == 0);
    end
  end

  // long receiver hold-off so the block backs up
  initial begin
    wait (fill_test);
    hold_rx = 1;
    repeat (300) @(posedge clk);
    hold_rx = 0;
  end

  initial begin
    #20ms;
    $display("[latlon_box_overlap_ratio_unit] ERROR");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t r;
    overlap_t z;
    logic [16:0] thr_set[5];
    thresh = lbo_pkg::THR_RESET;
    z.ratio = '0; z.match = 1'b0; z.st = lbo_pkg::ST_MISSING;

    r.known = 1;
    r.res = z; r.res.match = 1;
    r.bx = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(r);
    r.res = z;
    r.bx = mk(1, 1000, 0, 0, 1000, 0, 0, 0, 0, 0, 0, 0); rows.push_back(r);
    r.bx = mk(0, 0, 0, 0, 0, 1, 1, 1000, 0, 0, 1000, 1); rows.push_back(r);
    // identical boxes: one
    r.res.ratio = (RB+1)'(1) << RB; r.res.match = 1; r.res.st = lbo_pkg::ST_OK;
    r.bx = mk(1, 90000, -90000, -720000, 720000, 0, 1, 90000, -90000, -720000, 720000, 0);
    rows.push_back(r);
    r.bx = mk(1, 10000, 0, 0, 10000, 0, 1, 10000, 0, -360000, -350000, 0); rows.push_back(r);
    // empty union: north below south
    r.res = z; r.res.st = lbo_pkg::ST_EMPTY_UNION;
    r.bx = mk(1, -90000, 90000, 0, 1000, 0, 1, -90000, 90000, 0, 1000, 0); rows.push_back(r);
    r.known = 0;
    // disjoint boxes
    r.bx = mk(1, 10000, 0, 0, 10000, 0, 1, 50000, 40000, 100000, 110000, 0); rows.push_back(r);
    // half overlap
    r.bx = mk(1, 10000, 0, 0, 10000, 0, 1, 10000, 0, 5000, 15000, 0); rows.push_back(r);
    // south clamp for the special family, both sides
    r.bx = mk(1, -70000, -78000, 0, 10000, 1, 1, -70000, -90000, 0, 10000, 1); rows.push_back(r);
    r.bx = mk(1, -70000, -78000, 0, 10000, 0, 1, -70000, -77999, 0, 10000, 1); rows.push_back(r);
    // zero-height union, same latitude line
    r.bx = mk(1, 5000, 5000, 0, 10000, 0, 1, 5000, 5000, 5000, 20000, 0); rows.push_back(r);
    // zero-height rows at different latitudes inside height zero union impossible:
    // one flat box inside a tall one
    r.bx = mk(1, 5000, 5000, 0, 10000, 0, 1, 6000, 4000, 0, 10000, 0); rows.push_back(r);
    // west equal to east wraps a full turn
    r.bx = mk(1, 1000, 0, 7000, 7000, 0, 1, 1000, 0, -720000, -720000, 0); rows.push_back(r);
    // reversed edges, wrap
    r.bx = mk(1, 1000, -1000, 350000, 10000, 0, 1, 2000, 0, -10000, 5000, 0); rows.push_back(r);
    // raw extremes of the bit patterns
    r.bx = mk(1, 131071, -131072, 1048575, -1048576, 1, 1, -131072, 131071,
              -1048576, 1048575, 1); rows.push_back(r);
    r.bx = mk(1, 131071, -131072, -1048576, 1048575, 0, 1, 131071, -131072,
              -1048576, 1048575, 1); rows.push_back(r);
    r.bx = mk(1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0); rows.push_back(r);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (rows[i]) begin
      send_pair(rows[i].bx);
      if (rows[i].known) begin
        z = expected_q[$];
        if (z.ratio !== rows[i].res.ratio || z.match !== rows[i].res.match ||
            z.st !== rows[i].res.st) report("table row", i, -1);
      end
    end
    drain();

    // random phases over several thresholds
    thr_set = '{17'd0, 17'd65536, 17'd45875, 17'd32768, 17'd131071};
    for (int p = 0; p < 5; p++) begin
      write_thresh(p == 4 ? 17'($urandom) : thr_set[p]);
      if (p == 2) fill_test = 1;
      for (int i = 0; i < 160; i++) send_pair(rand_pair());
      fill_test = 0;
      drain();
    end

    if (errors == 0) begin
      $display("[latlon_box_overlap_ratio_unit] OK");
    end else begin
      $display("[latlon_box_overlap_ratio_unit] ERROR");
    end
    $finish;
  end

endmodule
